>>> rtl/rl_pkg.sv
`default_nettype none
package rl_pkg;

  localparam int KindW  = 4;
  localparam int ResW   = 4;
  localparam int AmtW   = 16;
  localparam int CntW   = 15;
  localparam int DrvW   = 16;
  localparam int CalcW  = 18;   // headroom for differences of three counters
  localparam int InTdataW  = 24;
  localparam int OutTdataW = 96;

  typedef enum logic [KindW-1:0] {
    KIND_ADD         = 4'd0,
    KIND_REMOVE      = 4'd1,
    KIND_RESERVE_OUT = 4'd2,
    KIND_RELEASE_OUT = 4'd3,
    KIND_CONSUME_OUT = 4'd4,
    KIND_RESERVE_IN  = 4'd5,
    KIND_RELEASE_IN  = 4'd6,
    KIND_COMMIT_IN   = 4'd7,
    KIND_SET_CAP     = 4'd8,
    KIND_QUERY       = 4'd9
  } kind_e;

  typedef struct packed {
    logic [CntW-1:0] in_res;
    logic [CntW-1:0] out_res;
    logic [CntW-1:0] limit;
    logic [CntW-1:0] held;
  } entry_t;

  typedef struct packed {
    logic signed [DrvW-1:0] room;
    logic signed [DrvW-1:0] spare;
    entry_t                 entry;
    logic                   ok;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/rl_table.sv
`default_nettype none
module rl_table #(
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [ADDR_W-1:0]   rd_addr_i,
  output rl_pkg::entry_t           rd_entry_o,
  input  wire logic                wr_en_i,
  input  wire logic [ADDR_W-1:0]   wr_addr_i,
  input  wire rl_pkg::entry_t      wr_entry_i
);

  rl_pkg::entry_t   mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  rl_pkg::entry_t   rd_data_q;
  logic             rd_valid_q;

  // storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits: an unwritten entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

>>> rtl/rl_alu.sv
`default_nettype none
module rl_alu (
  input  wire logic [rl_pkg::KindW-1:0]        kind_i,
  input  wire logic signed [rl_pkg::AmtW-1:0]  amount_i,
  input  wire rl_pkg::entry_t                  cur_i,
  output rl_pkg::result_t                      res_o
);

  logic signed [rl_pkg::CalcW-1:0] h, c, o, i, a;
  logic signed [rl_pkg::CalcW-1:0] nh, nc, no, ni;
  logic signed [rl_pkg::CalcW-1:0] free, avail, new_cap;
  logic signed [rl_pkg::CalcW-1:0] spare, room;
  logic                            neg, ok;

  always_comb begin
    h = $signed({3'b000, cur_i.held});
    c = $signed({3'b000, cur_i.limit});
    o = $signed({3'b000, cur_i.out_res});
    i = $signed({3'b000, cur_i.in_res});
    a = {{(rl_pkg::CalcW - rl_pkg::AmtW){amount_i[rl_pkg::AmtW-1]}}, amount_i};
    neg   = amount_i[rl_pkg::AmtW-1];
    free  = c - h - i;
    avail = h - o;
    new_cap = neg ? '0 : $signed({3'b000, amount_i[rl_pkg::CntW-1:0]});
    nh = h;
    nc = c;
    no = o;
    ni = i;
    ok = 1'b0;
    unique case (rl_pkg::kind_e'(kind_i))
      rl_pkg::KIND_ADD: begin
        if (!neg && free >= a) begin
          nh = h + a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_REMOVE: begin
        if (!neg && avail >= a) begin
          nh = h - a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_RESERVE_OUT: begin
        if (!neg && avail >= a) begin
          no = o + a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_RELEASE_OUT: begin
        if (!neg && o >= a) begin
          no = o - a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_CONSUME_OUT: begin
        if (!neg && o >= a && h >= a) begin
          no = o - a;
          nh = h - a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_RESERVE_IN: begin
        if (!neg && free >= a) begin
          ni = i + a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_RELEASE_IN: begin
        if (!neg && i >= a) begin
          ni = i - a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_COMMIT_IN: begin
        // limit - held - (in - a) >= a reduces to free >= 0
        if (!neg && i >= a && free >= 0) begin
          ni = i - a;
          nh = h + a;
          ok = 1'b1;
        end
      end
      rl_pkg::KIND_SET_CAP: begin
        nc = new_cap;
        nh = (h > new_cap) ? new_cap : h;
        ok = 1'b1;
      end
      rl_pkg::KIND_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    spare = nh - no;
    room  = nc - nh - ni;
    res_o.ok            = ok;
    res_o.entry.held    = nh[rl_pkg::CntW-1:0];
    res_o.entry.limit   = nc[rl_pkg::CntW-1:0];
    res_o.entry.out_res = no[rl_pkg::CntW-1:0];
    res_o.entry.in_res  = ni[rl_pkg::CntW-1:0];
    res_o.spare         = spare[rl_pkg::DrvW-1:0];
    res_o.room          = room[rl_pkg::DrvW-1:0];
  end

endmodule
`default_nettype wire

>>> rtl/reservation_ledger.sv
`default_nettype none
// Reservation ledger: one entry per resource with held quantity, capacity,
// reserved outgoing and reserved incoming counters, all zero after reset.
// Each input transaction names an operation, a resource and a signed amount;
// the operation is applied in full or refused, and exactly one result
// transaction follows with the ok flag, the entry after the operation and
// the derived values spare_to_take = held - reserved out and
// room_left = capacity - held - reserved in. A resource at or above
// RESOURCE_ENTRIES gives ok = 0 and all other result fields zero.
// Each transaction first does a synchronous read of the entry table, then is
// evaluated and written back once the output register is free or draining. One
// transaction is in flight at a time, so a read never sees a stale entry and
// no forwarding is needed. The finished result sits in an output register,
// so the next input is taken while that result waits for m_axis_tready.
// Reset clears per-entry valid bits at once; there is no clearing pass.
module reservation_ledger #(
  parameter int RESOURCE_ENTRIES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [3:0] resource, [19:4] amount, [23:20] zero
  input  wire logic [rl_pkg::InTdataW-1:0]     s_axis_tdata,
  // [3:0] kind
  input  wire logic [rl_pkg::KindW-1:0]        s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [0] ok, [15:1] held, [30:16] limit, [45:31] held_back_out,
  // [60:46] promised_in, [76:61] spare_to_take, [92:77] room_left, [95:93] zero
  output logic [rl_pkg::OutTdataW-1:0]         m_axis_tdata
);

  // Only 16 resources are addressable through the 4-bit field.
  localparam int Depth = (RESOURCE_ENTRIES < 16) ? RESOURCE_ENTRIES : 16;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ResW  = $bits(rl_pkg::result_t);

  logic [rl_pkg::KindW-1:0]       in_kind;
  logic [rl_pkg::ResW-1:0]        in_res;
  logic signed [rl_pkg::AmtW-1:0] in_amount;
  logic                           in_range;
  logic                           accept;
  logic                           done;

  // operation held while the entry is read
  logic                           busy_q, busy_d;
  logic [rl_pkg::KindW-1:0]       kind_q;
  logic signed [rl_pkg::AmtW-1:0] amount_q;
  logic [AddrW-1:0]               addr_q;
  logic                           in_range_q;

  // output register
  logic                           out_valid_q, out_valid_d;
  rl_pkg::result_t                out_q;

  rl_pkg::entry_t                 rd_entry;
  rl_pkg::result_t                alu_res;

  assign in_kind   = s_axis_tuser;
  assign in_res    = s_axis_tdata[3:0];
  assign in_amount = $signed(s_axis_tdata[19:4]);
  assign in_range  = 32'(in_res) < RESOURCE_ENTRIES;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // finish only when the output register is free or draining
  assign done          = busy_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= in_kind;
      amount_q   <= in_amount;
      addr_q     <= in_res[AddrW-1:0];
      in_range_q <= in_range;
    end
    if (done) begin
      out_q <= in_range_q ? alu_res : '0;
    end
  end

  rl_table #(
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept && in_range),
    .rd_addr_i  (in_res[AddrW-1:0]),
    .rd_entry_o (rd_entry),
    .wr_en_i    (done && in_range_q),
    .wr_addr_i  (addr_q),
    .wr_entry_i (alu_res.entry)
  );

  rl_alu u_alu (
    .kind_i   (kind_q),
    .amount_i (amount_q),
    .cur_i    (rd_entry),
    .res_o    (alu_res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(rl_pkg::OutTdataW - ResW){1'b0}}, out_q};

  // an accepted transaction always occupies the compute stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("accepted transaction did not enter compute stage");

  // a new result only appears after the compute stage finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(busy_q))
    else $error("result valid without a transaction in flight");

  // held never exceeds capacity in any reported entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.entry.held <= out_q.entry.limit))
    else $error("held exceeds limit");

endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 3;
  localparam int LedgerSize   = 16;
  localparam int RandomItems  = 2000;
  localparam int HoldAt       = 700;     // accepted transactions before the long hold-off
  localparam int LongHold     = 400;     // cycles of receiver hold-off
  localparam int DrainCycles  = 20;
  localparam int RunLimit     = 400000;
  localparam int KindW        = rl_pkg::KindW;
  localparam int ResW         = rl_pkg::ResW;
  localparam int AmtW         = rl_pkg::AmtW;
  localparam int CntW         = rl_pkg::CntW;
  localparam int DrvW         = rl_pkg::DrvW;
  localparam int InTdataW     = rl_pkg::InTdataW;
  localparam int OutTdataW    = rl_pkg::OutTdataW;
  localparam int ResultW      = $bits(rl_pkg::result_t);

  // Undefined operation codes: change nothing, ok = 0, entry reported as for a query.
  localparam logic [KindW-1:0] KIND_UNDEF_LO = 4'd10;
  localparam logic [KindW-1:0] KIND_UNDEF_HI = 4'd15;

  typedef struct packed {
    logic signed [AmtW-1:0] amt;
    logic [ResW-1:0]        res;
    logic [KindW-1:0]       kind;
  } request_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_MOSTLY} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // [3:0] resource, [19:4] amount, [23:20] zero
  logic [InTdataW-1:0] s_axis_tdata = '0;
  // [3:0] kind
  logic [KindW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // [0] ok, [15:1] held, [30:16] limit, [45:31] held_back_out,
  // [60:46] promised_in, [76:61] spare_to_take, [92:77] room_left, [95:93] zero
  logic [OutTdataW-1:0] m_axis_tdata;

  reservation_ledger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Ledger copy kept by the checker.
  logic [CntW-1:0] held_mem    [LedgerSize];
  logic [CntW-1:0] cap_mem     [LedgerSize];
  logic [CntW-1:0] out_res_mem [LedgerSize];
  logic [CntW-1:0] in_res_mem  [LedgerSize];

  request_t         request_q[$];        // stimulus not yet offered
  rl_pkg::result_t  pending_results[$];  // predicted results, oldest first

  int items_total;
  int items_taken;
  int results_seen;
  int mismatch_cnt;
  int cycle_cnt;
  logic in_taken = 1'b0;         // input transaction completed at the last rising edge

  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int mode_left;
  int rx_phase;
  rx_mode_e rx_mode;

  initial begin
    for (int k = 0; k < LedgerSize; k++) begin
      held_mem[k]    = '0;
      cap_mem[k]     = '0;
      out_res_mem[k] = '0;
      in_res_mem[k]  = '0;
    end
  end

  // Apply one operation to the ledger copy and return the result it gives.
  function automatic rl_pkg::result_t ledger_apply(request_t rq);
    int h, c, o, i, amt;
    logic ok;
    rl_pkg::result_t r;
    r = '0;
    if (int'(rq.res) >= LedgerSize) return r;
    h   = held_mem[rq.res];
    c   = cap_mem[rq.res];
    o   = out_res_mem[rq.res];
    i   = in_res_mem[rq.res];
    amt = rq.amt;
    ok  = 1'b0;
    case (rq.kind)
      rl_pkg::KIND_ADD:
        if (amt >= 0 && c - h - i >= amt) begin
          h += amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_REMOVE:
        if (amt >= 0 && h - o >= amt) begin
          h -= amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_RESERVE_OUT:
        if (amt >= 0 && h - o >= amt) begin
          o += amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_RELEASE_OUT:
        if (amt >= 0 && o >= amt) begin
          o -= amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_CONSUME_OUT:
        if (amt >= 0 && o >= amt && h >= amt) begin
          o -= amt;
          h -= amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_RESERVE_IN:
        if (amt >= 0 && c - h - i >= amt) begin
          i += amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_RELEASE_IN:
        if (amt >= 0 && i >= amt) begin
          i -= amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_COMMIT_IN:
        // room is judged with the committed part already out of the reserve
        if (amt >= 0 && i >= amt && c - h - (i - amt) >= amt) begin
          i -= amt;
          h += amt;
          ok = 1'b1;
        end
      rl_pkg::KIND_SET_CAP: begin
        c = (amt < 0) ? 0 : amt;
        if (h > c) h = c;
        ok = 1'b1;
      end
      rl_pkg::KIND_QUERY: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    held_mem[rq.res]    = CntW'(h);
    cap_mem[rq.res]     = CntW'(c);
    out_res_mem[rq.res] = CntW'(o);
    in_res_mem[rq.res]  = CntW'(i);
    r.ok            = ok;
    r.entry.held    = CntW'(h);
    r.entry.limit   = CntW'(c);
    r.entry.out_res = CntW'(o);
    r.entry.in_res  = CntW'(i);
    r.spare         = DrvW'(h - o);
    r.room          = DrvW'(c - h - i);
    return r;
  endfunction

  function automatic void queue_request(logic [KindW-1:0] k, int r, int a);
    request_t rq;
    rq.kind = k;
    rq.res  = ResW'(r);
    rq.amt  = AmtW'(a);
    request_q.push_back(rq);
  endfunction

  // Mostly small quantities so that operations succeed; some negative and full-range.
  function automatic int pick_amount();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return $urandom_range(0, 32767) - 32768;
    if (sel < 16) return $urandom_range(0, 32767);
    if (sel < 70) return $urandom_range(0, 40);
    return $urandom_range(0, 2000);
  endfunction

  function automatic int pick_cap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return $urandom_range(0, 32767) - 32768;
    if (sel < 16) return 32767;
    if (sel < 22) return 0;
    if (sel < 75) return $urandom_range(1, 200);
    return $urandom_range(0, 3000);
  endfunction

  function automatic int pick_resource();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
  endfunction

  // Lifecycle of one resource: capacity, stock, outgoing and incoming reservations.
  // Cut short at random to give broken sequences.
  function automatic int queue_lifecycle();
    int r, cap, a, b, c, d, e, len;
    request_t seq[10];
    r   = pick_resource();
    cap = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(1, 300);
    a   = $urandom_range(0, cap);
    b   = $urandom_range(0, a);
    c   = $urandom_range(0, b);
    d   = $urandom_range(0, cap - a);
    e   = $urandom_range(0, d);
    seq[0] = '{amt: AmtW'(cap),   res: ResW'(r), kind: rl_pkg::KIND_SET_CAP};
    seq[1] = '{amt: AmtW'(a),     res: ResW'(r), kind: rl_pkg::KIND_ADD};
    seq[2] = '{amt: AmtW'(b),     res: ResW'(r), kind: rl_pkg::KIND_RESERVE_OUT};
    seq[3] = '{amt: AmtW'(c),     res: ResW'(r), kind: rl_pkg::KIND_CONSUME_OUT};
    seq[4] = '{amt: AmtW'(b - c), res: ResW'(r), kind: rl_pkg::KIND_RELEASE_OUT};
    seq[5] = '{amt: AmtW'(d),     res: ResW'(r), kind: rl_pkg::KIND_RESERVE_IN};
    seq[6] = '{amt: AmtW'(e),     res: ResW'(r), kind: rl_pkg::KIND_COMMIT_IN};
    seq[7] = '{amt: AmtW'(d - e), res: ResW'(r), kind: rl_pkg::KIND_RELEASE_IN};
    seq[8] = '{amt: AmtW'($urandom_range(0, a)), res: ResW'(r), kind: rl_pkg::KIND_REMOVE};
    seq[9] = '{amt: '0,           res: ResW'(r), kind: rl_pkg::KIND_QUERY};
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 9) : 10;
    for (int j = 0; j < len; j++) request_q.push_back(seq[j]);
    return len;
  endfunction

  function automatic void queue_noise();
    logic [KindW-1:0] k;
    if ($urandom_range(0, 99) < 4) k = KindW'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    else k = KindW'($urandom_range(rl_pkg::KIND_ADD, rl_pkg::KIND_QUERY));
    queue_request(k, pick_resource(), (k == rl_pkg::KIND_SET_CAP) ? pick_cap() : pick_amount());
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [DrvW-1:0] got_v, logic [DrvW-1:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d field %s: got %h, want %h",
                                results_seen, name, got_v, want_v));
  endtask

  // Stimulus and end of run.
  initial begin
    int n;
    // directed: extremes, each op but release-in, negative amounts, clamping, undefined codes
    queue_request(rl_pkg::KIND_QUERY,       0, 0);
    queue_request(rl_pkg::KIND_ADD,         0, 1);        // no capacity yet
    queue_request(rl_pkg::KIND_SET_CAP,     0, 32767);
    queue_request(rl_pkg::KIND_ADD,         0, 32767);    // fills to the limit
    queue_request(rl_pkg::KIND_ADD,         0, 1);
    queue_request(rl_pkg::KIND_REMOVE,      0, -1);       // negative amount
    queue_request(rl_pkg::KIND_RESERVE_OUT, 0, 32767);
    queue_request(rl_pkg::KIND_REMOVE,      0, 1);        // nothing available
    queue_request(rl_pkg::KIND_RELEASE_OUT, 0, -32768);
    queue_request(rl_pkg::KIND_CONSUME_OUT, 0, 100);
    queue_request(rl_pkg::KIND_RELEASE_OUT, 0, 32667);
    queue_request(rl_pkg::KIND_SET_CAP,     0, -32768);   // clamps to zero, held follows
    queue_request(rl_pkg::KIND_SET_CAP,     15, 1000);
    queue_request(rl_pkg::KIND_RESERVE_IN,  15, 1000);
    queue_request(rl_pkg::KIND_ADD,         15, 1);       // room taken by the incoming reserve
    queue_request(rl_pkg::KIND_COMMIT_IN,   15, 1000);
    queue_request(rl_pkg::KIND_RESERVE_OUT, 15, 300);
    queue_request(rl_pkg::KIND_SET_CAP,     15, 100);     // reserved out now above held
    queue_request(rl_pkg::KIND_CONSUME_OUT, 15, 200);
    queue_request(rl_pkg::KIND_SET_CAP,     5, 50);
    queue_request(rl_pkg::KIND_RESERVE_IN,  5, 50);
    queue_request(rl_pkg::KIND_SET_CAP,     5, 10);
    queue_request(rl_pkg::KIND_COMMIT_IN,   5, 20);       // reserve covers it, room does not
    queue_request(KIND_UNDEF_HI,            15, 5);
    queue_request(KIND_UNDEF_LO,            0, -7);
    n = 0;
    while (n < RandomItems) begin
      if ($urandom_range(0, 9) < 6) n += queue_lifecycle();
      else begin
        queue_noise();
        n++;
      end
    end
    items_total = request_q.size();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (items_taken < items_total || pending_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= RunLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Driver: bursts of random length, random gaps between them (sometimes none).
  always @(negedge clk_i) begin
    request_t rq;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (request_q.size() > 0) begin
        rq = request_q.pop_front();
        s_axis_tdata  <= {4'b0000, rq.amt, rq.res};
        s_axis_tuser  <= rq.kind;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off once traffic is going, otherwise a changing stall pattern.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && items_taken >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = LongHold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(RX_OPEN, RX_MOSTLY));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        rx_phase++;
        case (rx_mode)
          RX_OPEN:        m_axis_tready <= 1'b1;
          RX_COIN:        m_axis_tready <= 1'($urandom_range(0, 1));
          RX_EVERY_THIRD: m_axis_tready <= (rx_phase % 3 == 0);
          default:        m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: check each result transaction, predict from each input transaction.
  // A result never belongs to an input taken at the same edge, so the order is safe.
  always @(posedge clk_i) begin
    rl_pkg::result_t got, want;
    request_t seen;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[ResultW-1:0];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = pending_results.pop_front();
          compare_field("ok",            DrvW'(got.ok),            DrvW'(want.ok));
          compare_field("held",          DrvW'(got.entry.held),    DrvW'(want.entry.held));
          compare_field("limit",         DrvW'(got.entry.limit),   DrvW'(want.entry.limit));
          compare_field("held_back_out", DrvW'(got.entry.out_res), DrvW'(want.entry.out_res));
          compare_field("promised_in",   DrvW'(got.entry.in_res),  DrvW'(want.entry.in_res));
          compare_field("spare_to_take", got.spare,                want.spare);
          compare_field("room_left",     got.room,                 want.room);
          compare_field("padding",       DrvW'(m_axis_tdata[OutTdataW-1:ResultW]), '0);
        end
        results_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen.kind = s_axis_tuser;
        seen.res  = s_axis_tdata[3:0];
        seen.amt  = s_axis_tdata[19:4];
        pending_results.push_back(ledger_apply(seen));
        items_taken++;
      end
    end
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

endmodule

>>> sim.f
rtl/rl_pkg.sv
rtl/rl_table.sv
rtl/rl_alu.sv
rtl/reservation_ledger.sv
dv/testbench.sv
